### rtl/core/irpwc_pkg.sv
package irpwc_pkg;

    // slot limit applied on top of the buffer_slots register
    localparam int MAX_SLOTS = 1024;
    // default width of the tick counters
    localparam int COUNT_WIDTH = 16;

    localparam int SLOTS_W = 11;
    localparam int TIME_W = 16;
    localparam int DUR_W = 16;
    localparam int SLOT_IDX_W = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [DUR_W-1:0] ABORT_CODE = 16'hEEEE;

    localparam logic [SLOTS_W-1:0] BUFFER_SLOTS_RESET = 11'd64;
    localparam logic [TIME_W-1:0] PAUSE_TIMEOUT_RESET = 16'd10000;
    localparam logic [TIME_W-1:0] QUIET_TICKS_RESET = 16'd1000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SLOTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_TICKS = 2'd2;

    // input operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef struct packed {
        logic [SLOTS_W-1:0] buffer_slots;
        logic [TIME_W-1:0]  pause_timeout;
        logic [TIME_W-1:0]  quiet_ticks;
    } cfg_t;

    typedef struct packed {
        logic                  duration_valid;
        logic [DUR_W-1:0]      duration;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic                  abort_marker;
        logic                  capture_done;
        logic [SLOTS_W-1:0]    count_read;
        logic                  indicator_on;
    } result_t;

    function automatic logic [SLOTS_W-1:0] slot_limit(input logic [SLOTS_W-1:0] slots);
        slot_limit = (32'(slots) > MAX_SLOTS) ? SLOTS_W'(MAX_SLOTS) : slots;
    endfunction

endpackage

### rtl/core/irpwc_engine.sv
module irpwc_engine
    import irpwc_pkg::*;
#(
    parameter int COUNT_W = COUNT_WIDTH
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step_en,
    input  logic    operation,
    input  logic    line_active,
    input  cfg_t    cfg,
    output result_t result
);

    localparam int CMP_W = (COUNT_W > TIME_W) ? COUNT_W : TIME_W;
    localparam logic [COUNT_W-1:0] CNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] CNT_ONE = COUNT_W'(1);

    typedef enum logic [2:0] {
        PH_START,
        PH_PULSE,
        PH_PAUSE,
        PH_QUIET,
        PH_DONE
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] pulse_count_reg, pulse_count_next;
    logic [COUNT_W-1:0] pause_count_reg, pause_count_next;
    logic [COUNT_W-1:0] quiet_count_reg, quiet_count_next;
    logic [SLOTS_W-1:0] write_index_reg, write_index_next;
    logic [SLOTS_W-1:0] slots_read_reg, slots_read_next;
    logic               indicator_reg, indicator_next;

    logic [SLOTS_W-1:0] limit;
    logic [SLOTS_W-1:0] index_inc;
    logic [COUNT_W-1:0] quiet_base;
    logic [COUNT_W-1:0] pause_inc;
    logic [COUNT_W-1:0] run_len;
    logic [CMP_W-1:0]   run_len_ext;
    logic               in_pulse;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + CNT_ONE;
    endfunction

    assign limit = slot_limit(cfg.buffer_slots);
    assign index_inc = write_index_reg + SLOTS_W'(1);
    assign quiet_base = line_active ? '0 : quiet_count_reg;
    assign pause_inc = sat_inc(pause_count_reg);
    assign in_pulse = (phase_reg == PH_PULSE);
    assign run_len = in_pulse ? pulse_count_reg : pause_count_reg;
    assign run_len_ext = CMP_W'(run_len);

    always_comb begin
        phase_next = phase_reg;
        pulse_count_next = pulse_count_reg;
        pause_count_next = pause_count_reg;
        quiet_count_next = quiet_count_reg;
        write_index_next = write_index_reg;
        slots_read_next = slots_read_reg;
        indicator_next = indicator_reg;
        result.duration_valid = 1'b0;
        result.duration = '0;
        result.slot_index = '0;
        result.abort_marker = 1'b0;

        if (operation == OP_START) begin
            phase_next = PH_START;
            slots_read_next = '0;
            write_index_next = '0;
        end else begin
            unique case (phase_reg)
                PH_QUIET: begin
                    if (CMP_W'(quiet_base) >= CMP_W'(cfg.quiet_ticks)) begin
                        phase_next = PH_DONE;
                        quiet_count_next = '0;
                    end else begin
                        quiet_count_next = sat_inc(quiet_base);
                    end
                end
                PH_DONE: begin
                    indicator_next = 1'b0;
                end
                PH_START: begin
                    if (line_active) begin
                        indicator_next = 1'b1;
                        phase_next = PH_PULSE;
                        pause_count_next = '0;
                        pulse_count_next = CNT_ONE;
                    end
                end
                PH_PULSE, PH_PAUSE: begin
                    if (in_pulse && line_active) begin
                        pulse_count_next = sat_inc(pulse_count_reg);
                    end else if (!in_pulse && !line_active) begin
                        pause_count_next = pause_inc;
                        if (CMP_W'(pause_inc) >= CMP_W'(cfg.pause_timeout)) begin
                            result.duration_valid = 1'b1;
                            result.abort_marker = 1'b1;
                            result.duration = ABORT_CODE;
                            result.slot_index = write_index_reg[SLOT_IDX_W-1:0];
                            slots_read_next = index_inc;
                            write_index_next = '0;
                            pause_count_next = '0;
                            phase_next = PH_QUIET;
                        end
                    end else begin
                        // run ended: write its length to the current slot
                        result.duration_valid = 1'b1;
                        result.duration = (run_len_ext > CMP_W'(16'hFFFF)) ? 16'hFFFF
                                                                          : run_len_ext[DUR_W-1:0];
                        result.slot_index = write_index_reg[SLOT_IDX_W-1:0];
                        write_index_next = index_inc;
                        if (index_inc >= limit) begin
                            slots_read_next = limit;
                            phase_next = PH_QUIET;
                        end else if (in_pulse) begin
                            pulse_count_next = '0;
                            pause_count_next = CNT_ONE;
                            phase_next = PH_PAUSE;
                        end else begin
                            pause_count_next = '0;
                            pulse_count_next = CNT_ONE;
                            phase_next = PH_PULSE;
                        end
                    end
                end
                default: begin
                    phase_next = PH_START;
                end
            endcase
        end

        result.capture_done = (phase_next == PH_DONE);
        result.count_read = (phase_next == PH_DONE) ? slots_read_next : '0;
        result.indicator_on = indicator_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            pulse_count_reg <= '0;
            pause_count_reg <= '0;
            quiet_count_reg <= '0;
            write_index_reg <= '0;
            slots_read_reg <= '0;
            indicator_reg <= 1'b0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            pulse_count_reg <= pulse_count_next;
            pause_count_reg <= pause_count_next;
            quiet_count_reg <= quiet_count_next;
            write_index_reg <= write_index_next;
            slots_read_reg <= slots_read_next;
            indicator_reg <= indicator_next;
        end
    end

    a_abort_enters_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && result.abort_marker |=> phase_reg == PH_QUIET && pause_count_reg == '0)
        else $error("abort did not move capture to quiet wait");

    a_done_clears_indicator: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && operation == OP_TICK && phase_reg == PH_DONE |=> !indicator_reg)
        else $error("indicator still on after tick in done phase");

    a_start_clears_slots: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && operation == OP_START |=> phase_reg == PH_START && write_index_reg == '0
                                              && slots_read_reg == '0)
        else $error("start command did not reset capture");

endmodule

### rtl/core/ir_pulse_width_capture_core.sv
// Raw infrared pulse/pause capture. Each s_ transaction is one sample tick of the
// active-high receiver line, or a start command; every transaction yields exactly one
// m_ transaction with the run length written this tick (if any), its slot, the abort
// flag, the done status with the number of slots read, and the activity indicator.
// One transaction is taken per clock cycle unless m_tready stalls; a result reaches
// m_ through the input register, then the result register, with the capture state
// updated by combinational compare and increment logic between the two. Stalls on
// m_tready back up into s_tready without losing or repeating results. Configuration
// writes are taken in any cycle and should be made while no transaction is in flight.
module ir_pulse_width_capture_core
    import irpwc_pkg::*;
#(
    parameter int COUNT_W = COUNT_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [0] line_active
    input  logic [0:0]            s_tuser,   // [0] operation

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,   // [15:0] duration, [25:16] slot_index,
                                             // [26] capture_done, [37:27] count_read,
                                             // [38] indicator_on
    output logic [1:0]            m_tuser,   // [0] duration_valid, [1] abort_marker

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    logic    op_reg;
    logic    act_reg;
    logic    out_valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    advance;
    logic    step_en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.buffer_slots <= BUFFER_SLOTS_RESET;
            cfg_reg.pause_timeout <= PAUSE_TIMEOUT_RESET;
            cfg_reg.quiet_ticks <= QUIET_TICKS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_BUFFER_SLOTS:  cfg_reg.buffer_slots <= cfg_data[SLOTS_W-1:0];
                CFG_PAUSE_TIMEOUT: cfg_reg.pause_timeout <= cfg_data[TIME_W-1:0];
                CFG_QUIET_TICKS:   cfg_reg.quiet_ticks <= cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // result register free or being emptied this cycle
    assign advance = !out_valid_reg || m_tready;
    assign step_en = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg <= s_tuser[0];
            act_reg <= s_tdata[0];
        end
    end

    irpwc_engine #(
        .COUNT_W (COUNT_W)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (step_en),
        .operation   (op_reg),
        .line_active (act_reg),
        .cfg         (cfg_reg),
        .result      (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {1'b0, result_reg.indicator_on, result_reg.count_read,
                      result_reg.capture_done, result_reg.slot_index, result_reg.duration};
    assign m_tuser = {result_reg.abort_marker, result_reg.duration_valid};

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(result_reg))
        else $error("pending result lost or changed under stall");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without a full pipeline");

    a_step_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en |=> out_valid_reg)
        else $error("processed transaction produced no result");

endmodule

### sim/tb_ir_pulse_width_capture_core.sv
`timescale 1ns / 1ps

module tb_ir_pulse_width_capture_core;
    import irpwc_pkg::*;

    localparam int CYCLE_LIMIT = 50_000;
    localparam int RANDOM_TICKS = 90;

    typedef enum logic [2:0] {
        CAP_START,
        CAP_PULSE,
        CAP_PAUSE,
        CAP_QUIET,
        CAP_DONE
    } cap_phase_t;

    typedef enum logic {
        ROW_TICK,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  op;
        logic                  act;
        bit                    fixed;
        result_t               res;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;   // [0] line_active
    logic [0:0]            s_tuser = '0;   // [0] operation
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [39:0]           m_tdata;        // [15:0] duration, [25:16] slot_index,
                                           // [26] capture_done, [37:27] count_read,
                                           // [38] indicator_on
    logic [1:0]            m_tuser;        // [0] duration_valid, [1] abort_marker
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor copy of the registers and capture state
    logic [SLOTS_W-1:0]     cfg_slots = BUFFER_SLOTS_RESET;
    logic [TIME_W-1:0]      cfg_timeout = PAUSE_TIMEOUT_RESET;
    logic [TIME_W-1:0]      cfg_quiet = QUIET_TICKS_RESET;
    cap_phase_t             cap_ph = CAP_START;
    logic [COUNT_WIDTH-1:0] pulse_cnt = '0;
    logic [COUNT_WIDTH-1:0] pause_cnt = '0;
    logic [COUNT_WIDTH-1:0] quiet_cnt = '0;
    logic [SLOTS_W-1:0]     wr_idx = '0;
    logic [SLOTS_W-1:0]     slots_rd = '0;
    logic                   led = 1'b0;

    result_t   predicted_ticks_q[$];
    stim_row_t dir_rows[$];

    int  clk_count = 0;
    int  err_count = 0;
    int  ticks_sent = 0;
    int  n_checked = 0;
    int  n_writes = 0;
    int  n_aborts = 0;
    int  n_done = 0;
    int  n_caps = 0;
    int  burst_left = 0;
    bit  pace_on = 1'b1;
    int  stall_mode = 0;

    ir_pulse_width_capture_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        clk_count <= clk_count + 1;
        if (clk_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [COUNT_WIDTH-1:0] sat_up(input logic [COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic result_t mk_res(input logic valid, input logic [DUR_W-1:0] dur,
                                       input logic [SLOT_IDX_W-1:0] slot, input logic abrt,
                                       input logic done, input logic [SLOTS_W-1:0] cnt,
                                       input logic ind);
        result_t r;
        r.duration_valid = valid;
        r.duration       = dur;
        r.slot_index     = slot;
        r.abort_marker   = abrt;
        r.capture_done   = done;
        r.count_read     = cnt;
        r.indicator_on   = ind;
        return r;
    endfunction

    // advances the capture state by one transaction and returns the output it causes
    function automatic result_t ir_capture_next(input logic op, input logic act);
        result_t r;
        int      lim;
        r = '0;
        lim = (int'(cfg_slots) > MAX_SLOTS) ? MAX_SLOTS : int'(cfg_slots);
        if (op == OP_START) begin
            cap_ph = CAP_START;
            slots_rd = '0;
            wr_idx = '0;
        end else begin
            case (cap_ph)
                CAP_QUIET: begin
                    if (act) quiet_cnt = '0;
                    if (quiet_cnt >= cfg_quiet) begin
                        cap_ph = CAP_DONE;
                        quiet_cnt = '0;
                    end else begin
                        quiet_cnt = sat_up(quiet_cnt);
                    end
                end
                CAP_DONE: led = 1'b0;
                CAP_START: begin
                    if (act) begin
                        led = 1'b1;
                        cap_ph = CAP_PULSE;
                        pause_cnt = '0;
                        pulse_cnt = 1;
                    end
                end
                CAP_PULSE, CAP_PAUSE: begin
                    if (cap_ph == CAP_PULSE && act) begin
                        pulse_cnt = sat_up(pulse_cnt);
                    end else if (cap_ph == CAP_PAUSE && !act) begin
                        pause_cnt = sat_up(pause_cnt);
                        if (pause_cnt >= cfg_timeout) begin
                            r.duration_valid = 1'b1;
                            r.abort_marker = 1'b1;
                            r.duration = ABORT_CODE;
                            r.slot_index = wr_idx[SLOT_IDX_W-1:0];
                            slots_rd = wr_idx + 1'b1;
                            wr_idx = '0;
                            pause_cnt = '0;
                            cap_ph = CAP_QUIET;
                        end
                    end else begin
                        // level change closes the current run
                        r.duration_valid = 1'b1;
                        r.duration = (cap_ph == CAP_PULSE) ? pulse_cnt : pause_cnt;
                        r.slot_index = wr_idx[SLOT_IDX_W-1:0];
                        wr_idx = wr_idx + 1'b1;
                        if (int'(wr_idx) >= lim) begin
                            slots_rd = SLOTS_W'(lim);
                            cap_ph = CAP_QUIET;
                        end else if (cap_ph == CAP_PULSE) begin
                            pulse_cnt = '0;
                            pause_cnt = 1;
                            cap_ph = CAP_PAUSE;
                        end else begin
                            pause_cnt = '0;
                            pulse_cnt = 1;
                            cap_ph = CAP_PULSE;
                        end
                    end
                end
                default: cap_ph = CAP_START;
            endcase
        end
        r.capture_done = (cap_ph == CAP_DONE);
        r.count_read = r.capture_done ? slots_rd : '0;
        r.indicator_on = led;
        return r;
    endfunction

    task automatic cmp_field(input string name, input int unsigned e, input int unsigned g);
        if (e != g) begin
            $error("%s mismatch: expected %0h, got %0h", name, e, g);
            err_count++;
        end
    endtask

    // result monitor and receiver stall pattern
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.duration       = m_tdata[15:0];
            got.slot_index     = m_tdata[25:16];
            got.capture_done   = m_tdata[26];
            got.count_read     = m_tdata[37:27];
            got.indicator_on   = m_tdata[38];
            got.duration_valid = m_tuser[0];
            got.abort_marker   = m_tuser[1];
            if (predicted_ticks_q.size() == 0) begin
                $error("result transaction with nothing expected");
                err_count++;
            end else begin
                want = predicted_ticks_q.pop_front();
                cmp_field("duration_valid", want.duration_valid, got.duration_valid);
                cmp_field("duration", want.duration, got.duration);
                cmp_field("slot_index", want.slot_index, got.slot_index);
                cmp_field("abort_marker", want.abort_marker, got.abort_marker);
                cmp_field("capture_done", want.capture_done, got.capture_done);
                cmp_field("count_read", want.count_read, got.count_read);
                cmp_field("indicator_on", want.indicator_on, got.indicator_on);
            end
            n_checked++;
            if (got.duration_valid) n_writes++;
            if (got.abort_marker) n_aborts++;
            if (got.capture_done) n_done++;
        end
        if (clk_count[5:0] == 0) stall_mode = $urandom_range(0, 3);
        if (!pace_on) begin
            m_tready <= 1'b1;
        end else begin
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= (clk_count[1:0] != 2'b00);
                2: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= (clk_count[4:3] != 2'b11);
            endcase
        end
    end

    task automatic send_tick(input logic op, input logic act, input bit fixed,
                             input result_t res);
        int gap;
        result_t p;
        if (pace_on && burst_left == 0) begin
            gap = $urandom_range(1, 5);
            burst_left = $urandom_range(1, 24);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, act};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (burst_left > 0) burst_left--;
        ticks_sent++;
        p = ir_capture_next(op, act);
        predicted_ticks_q.push_back(fixed ? res : p);
    endtask

    // stop sending and let every outstanding result come back
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (predicted_ticks_q.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_BUFFER_SLOTS:  cfg_slots = val[SLOTS_W-1:0];
            CFG_PAUSE_TIMEOUT: cfg_timeout = val;
            CFG_QUIET_TICKS:   cfg_quiet = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic row_tick(input logic op, input logic act, input bit fixed,
                            input result_t res);
        stim_row_t row;
        row = '{kind: ROW_TICK, idx: '0, data: '0, op: op, act: act, fixed: fixed, res: res};
        dir_rows.push_back(row);
    endtask

    task automatic row_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        stim_row_t row;
        row = '{kind: ROW_CFG, idx: idx, data: val, op: OP_TICK, act: 1'b0, fixed: 1'b0,
                res: '0};
        dir_rows.push_back(row);
    endtask

    // optional random ticks, a start, then alternating pulses and pauses, then an idle tail for the quiet wait
    task automatic run_capture(input int n_runs, input int max_pulse, input int max_gap,
                               input bit allow_restart);
        int i;
        int j;
        int len;
        len = $urandom_range(0, 2);
        for (i = 0; i < len; i++) begin
            send_tick(($urandom_range(0, 5) == 0) ? OP_START : OP_TICK,
                      1'($urandom_range(0, 1)), 1'b0, '0);
        end
        send_tick(OP_START, 1'($urandom_range(0, 1)), 1'b0, '0);
        len = $urandom_range(0, 3);
        for (i = 0; i < len; i++) send_tick(OP_TICK, 1'b0, 1'b0, '0);
        for (i = 0; i < n_runs; i++) begin
            len = $urandom_range(1, max_pulse);
            for (j = 0; j < len; j++) send_tick(OP_TICK, 1'b1, 1'b0, '0);
            len = $urandom_range(1, max_gap);
            for (j = 0; j < len; j++) send_tick(OP_TICK, 1'b0, 1'b0, '0);
            // broken sequence: restart in the middle of a capture
            if (allow_restart && $urandom_range(0, 39) == 0) begin
                send_tick(OP_START, 1'($urandom_range(0, 1)), 1'b0, '0);
            end
        end
        len = int'(cfg_quiet) + $urandom_range(1, 4);
        for (i = 0; i < len; i++) begin
            send_tick(OP_TICK, ($urandom_range(0, 9) == 0), 1'b0, '0);
        end
    endtask

    initial begin
        int k;
        int lim;
        int rand_base;

        // after reset, default registers
        row_tick(OP_TICK,  1'b0, 1'b1, mk_res(0, 0, 0, 0, 0, 0, 0));
        row_tick(OP_TICK,  1'b1, 1'b1, mk_res(0, 0, 0, 0, 0, 0, 1));
        // start keeps the indicator lit
        row_tick(OP_START, 1'b1, 1'b1, mk_res(0, 0, 0, 0, 0, 0, 1));
        row_tick(OP_TICK,  1'b0, 1'b1, mk_res(0, 0, 0, 0, 0, 0, 1));
        // zero slots: capture ends after the first write with nothing read
        row_cfg(CFG_BUFFER_SLOTS, 16'd0);
        row_cfg(CFG_PAUSE_TIMEOUT, 16'd1);
        row_cfg(CFG_QUIET_TICKS, 16'd0);
        row_tick(OP_TICK,  1'b1, 1'b1, mk_res(0, 0, 0, 0, 0, 0, 1));
        row_tick(OP_TICK,  1'b0, 1'b1, mk_res(1, 1, 0, 0, 0, 0, 1));
        row_tick(OP_TICK,  1'b0, 1'b1, mk_res(0, 0, 0, 0, 1, 0, 1));
        row_tick(OP_TICK,  1'b1, 1'b1, mk_res(0, 0, 0, 0, 1, 0, 0));
        row_tick(OP_START, 1'b0, 1'b1, mk_res(0, 0, 0, 0, 0, 0, 0));
        // pause timeout writes the marker in the current slot
        row_cfg(CFG_BUFFER_SLOTS, 16'd3);
        row_tick(OP_TICK,  1'b1, 1'b1, mk_res(0, 0, 0, 0, 0, 0, 1));
        row_tick(OP_TICK,  1'b0, 1'b1, mk_res(1, 1, 0, 0, 0, 0, 1));
        row_tick(OP_TICK,  1'b0, 1'b1, mk_res(1, ABORT_CODE, 1, 1, 0, 0, 1));
        row_tick(OP_TICK,  1'b0, 1'b1, mk_res(0, 0, 0, 0, 1, 2, 1));
        row_tick(OP_START, 1'b1, 1'b1, mk_res(0, 0, 0, 0, 0, 0, 1));
        // slot limit reached, then activity on the first tick of the quiet wait
        row_cfg(CFG_PAUSE_TIMEOUT, 16'd3);
        row_cfg(CFG_QUIET_TICKS, 16'd2);
        row_tick(OP_TICK,  1'b1, 1'b0, '0);
        row_tick(OP_TICK,  1'b1, 1'b0, '0);
        row_tick(OP_TICK,  1'b0, 1'b0, '0);
        row_tick(OP_TICK,  1'b1, 1'b0, '0);
        row_tick(OP_TICK,  1'b0, 1'b0, '0);
        row_tick(OP_TICK,  1'b1, 1'b0, '0);
        row_tick(OP_TICK,  1'b0, 1'b0, '0);
        row_tick(OP_TICK,  1'b0, 1'b0, '0);
        row_tick(OP_TICK,  1'b0, 1'b0, '0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (k = 0; k < dir_rows.size(); k++) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                settle();
                write_reg(dir_rows[k].idx, dir_rows[k].data);
            end else begin
                send_tick(dir_rows[k].op, dir_rows[k].act, dir_rows[k].fixed, dir_rows[k].res);
            end
        end

        // full buffer at full rate, slot register above the buffer size
        settle();
        write_reg(CFG_BUFFER_SLOTS, 16'h07FF);
        write_reg(CFG_QUIET_TICKS, 16'd0);
        pace_on = 1'b0;
        run_capture(514, 1, 1, 1'b0);
        settle();
        pace_on = 1'b1;

        // small registers before the random captures
        write_reg(CFG_BUFFER_SLOTS, 16'd5);
        write_reg(CFG_PAUSE_TIMEOUT, 16'd4);

        rand_base = ticks_sent;
        while (ticks_sent - rand_base < RANDOM_TICKS) begin
            settle();
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_BUFFER_SLOTS, ($urandom_range(0, 14) == 0) ?
                          16'($urandom_range(11, 40)) : 16'($urandom_range(0, 10)));
            end
            if ($urandom_range(0, 1)) write_reg(CFG_PAUSE_TIMEOUT, 16'($urandom_range(0, 8)));
            if ($urandom_range(0, 1)) write_reg(CFG_QUIET_TICKS, 16'($urandom_range(0, 6)));
            lim = (int'(cfg_slots) > MAX_SLOTS) ? MAX_SLOTS : int'(cfg_slots);
            run_capture($urandom_range(1, lim + 3), $urandom_range(1, 6),
                        int'(cfg_timeout) + 2, 1'b1);
            n_caps++;
        end

        settle();
        repeat (8) @(posedge aclk);
        if (predicted_ticks_q.size() != 0) begin
            $error("%0d expected results never arrived", predicted_ticks_q.size());
            err_count++;
        end
        $display("ticks sent %0d over %0d random captures, results checked %0d",
                 ticks_sent, n_caps, n_checked);
        $display("durations %0d, timeout markers %0d, done reports %0d, mismatches %0d",
                 n_writes, n_aborts, n_done, err_count);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
